// ===== hdl/protobuf_field_scanner_core_assert.svh =====
// Assertion macros shared by the scanner core.
`ifndef PROTOBUF_FIELD_SCANNER_CORE_ASSERT_SVH
`define PROTOBUF_FIELD_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define PFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define PFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

// ===== hdl/pfs_pkg.sv =====
// Types and constants of the protobuf field scanner.
package pfs_pkg;

    // Scan phase, one-hot.
    typedef enum logic [4:0] {
        PH_KEY    = 5'b00001,
        PH_VARINT = 5'b00010,
        PH_SKIP   = 5'b00100,
        PH_LENGTH = 5'b01000,
        PH_ERROR  = 5'b10000
    } phase_t;

    // Wire types carried in the low three key bits.
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LENGTH  = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    localparam int FIXED64_BYTES = 8;
    localparam int FIXED32_BYTES = 4;

    // Length varint group handling.
    localparam logic [5:0] SHIFT_STEP  = 6'd7;
    localparam logic [5:0] SHIFT_LIMIT = 6'd56;
    localparam logic [5:0] SHIFT_SAT   = 6'd63;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_WIRE  = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    // Configuration space.
    localparam int         ADDR_WIDTH        = 3;
    localparam logic       REG_COUNTED_FIELD = 1'b0;
    localparam int         FIELD_WIDTH       = 4;
    localparam logic [3:0] FIELD_RESET       = 4'd1;

    typedef struct packed {
        logic [31:0] payload_count;
        logic [1:0]  status;
    } result_t;

endpackage

// ===== hdl/pfs_byte_if.sv =====
// Input byte stream channel.
interface pfs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

// ===== hdl/pfs_result_if.sv =====
// Result channel: count and status of one message.
interface pfs_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] payload_count;
    logic [1:0]  status;

    modport source (output valid, output payload_count, output status, input ready);
    modport sink (input valid, input payload_count, input status, output ready);
endinterface

// ===== hdl/pfs_apb_regs.sv =====
// APB configuration register: counted field number.
module pfs_apb_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pfs_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [pfs_pkg::FIELD_WIDTH-1:0]  counted_field
);

    logic                             field_hit;
    logic [pfs_pkg::FIELD_WIDTH-1:0]  field_reg;
    logic [pfs_pkg::FIELD_WIDTH-1:0]  field_next;

    // word index sits above the byte offset
    assign field_hit = (paddr[pfs_pkg::ADDR_WIDTH-1] == pfs_pkg::REG_COUNTED_FIELD);

    always_comb
    begin
        field_next = field_reg;
        if (psel && penable && pwrite && field_hit)
        begin
            field_next = pwdata[pfs_pkg::FIELD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg <= pfs_pkg::FIELD_RESET;
        end
        else
        begin
            field_reg <= field_next;
        end
    end

    assign pready        = 1'b1;
    assign prdata        = field_hit ? {{(32-pfs_pkg::FIELD_WIDTH){1'b0}}, field_reg} : 32'd0;
    assign counted_field = field_reg;

endmodule

// ===== hdl/pfs_scanner.sv =====
// Scan state registers and the per-byte update.
module pfs_scanner #(
    parameter int COUNT_WIDTH  = 32,
    parameter int LENGTH_WIDTH = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [7:0]                       data_byte,
    input  logic                             last,
    input  logic [pfs_pkg::FIELD_WIDTH-1:0]  counted_field,
    output logic                             result_valid,
    output pfs_pkg::result_t                 result
);

    pfs_pkg::phase_t          phase_reg, phase_next, phase_step;
    logic [LENGTH_WIDTH-1:0]  skip_reg, skip_next, skip_step;
    logic [LENGTH_WIDTH-1:0]  len_reg, len_next, len_step;
    logic [5:0]               shift_reg, shift_next, shift_step;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next, count_step;

    logic [LENGTH_WIDTH-1:0]  group_placed;
    logic [LENGTH_WIDTH-1:0]  len_acc;
    logic [LENGTH_WIDTH-1:0]  skip_dec;
    logic [63:0]              count_wide;
    logic                     key_match;

    assign key_match    = ({1'b0, counted_field} == data_byte[7:3]);
    assign group_placed = LENGTH_WIDTH'(data_byte[6:0]) << shift_reg;
    // a group at the saturated position is dropped
    assign len_acc      = len_reg | ((shift_reg != pfs_pkg::SHIFT_SAT) ? group_placed : '0);
    assign skip_dec     = (skip_reg != '0) ? skip_reg - LENGTH_WIDTH'(1) : skip_reg;

    always_comb
    begin
        phase_step = phase_reg;
        skip_step  = skip_reg;
        len_step   = len_reg;
        shift_step = shift_reg;
        count_step = count_reg;
        case (phase_reg)
            pfs_pkg::PH_KEY:
            begin
                case (data_byte[2:0])
                    pfs_pkg::WT_VARINT:
                    begin
                        phase_step = pfs_pkg::PH_VARINT;
                    end
                    pfs_pkg::WT_FIXED64:
                    begin
                        skip_step  = LENGTH_WIDTH'(pfs_pkg::FIXED64_BYTES);
                        phase_step = pfs_pkg::PH_SKIP;
                    end
                    pfs_pkg::WT_FIXED32:
                    begin
                        skip_step  = LENGTH_WIDTH'(pfs_pkg::FIXED32_BYTES);
                        phase_step = pfs_pkg::PH_SKIP;
                    end
                    pfs_pkg::WT_LENGTH:
                    begin
                        if (key_match && (count_reg != '1))
                        begin
                            count_step = count_reg + COUNT_WIDTH'(1);
                        end
                        len_step   = '0;
                        shift_step = '0;
                        phase_step = pfs_pkg::PH_LENGTH;
                    end
                    default:
                    begin
                        phase_step = pfs_pkg::PH_ERROR;
                    end
                endcase
            end
            pfs_pkg::PH_VARINT:
            begin
                if (!data_byte[7])
                begin
                    phase_step = pfs_pkg::PH_KEY;
                end
            end
            pfs_pkg::PH_SKIP:
            begin
                skip_step = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_step = pfs_pkg::PH_KEY;
                end
            end
            pfs_pkg::PH_LENGTH:
            begin
                len_step   = len_acc;
                shift_step = (shift_reg > pfs_pkg::SHIFT_LIMIT) ? pfs_pkg::SHIFT_SAT
                                                                : shift_reg + pfs_pkg::SHIFT_STEP;
                if (!data_byte[7])
                begin
                    skip_step  = len_acc;
                    len_step   = '0;
                    shift_step = '0;
                    phase_step = (len_acc == '0) ? pfs_pkg::PH_KEY : pfs_pkg::PH_SKIP;
                end
            end
            default:
            begin
                phase_step = pfs_pkg::PH_ERROR;
            end
        endcase
    end

    // clear the whole scan at the end of a message
    always_comb
    begin
        if (last)
        begin
            phase_next = pfs_pkg::PH_KEY;
            skip_next  = '0;
            len_next   = '0;
            shift_next = '0;
            count_next = '0;
        end
        else
        begin
            phase_next = phase_step;
            skip_next  = skip_step;
            len_next   = len_step;
            shift_next = shift_step;
            count_next = count_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pfs_pkg::PH_KEY;
            skip_reg  <= '0;
            len_reg   <= '0;
            shift_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            len_reg   <= len_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
        end
    end

    assign count_wide   = 64'(count_step);
    assign result_valid = accept && last;

    always_comb
    begin
        result.payload_count = (count_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : count_wide[31:0];
        if (phase_step == pfs_pkg::PH_ERROR)
        begin
            result.status = pfs_pkg::STATUS_BAD_WIRE;
        end
        else if (phase_step != pfs_pkg::PH_KEY)
        begin
            result.status = pfs_pkg::STATUS_TRUNCATED;
        end
        else
        begin
            result.status = pfs_pkg::STATUS_OK;
        end
    end

endmodule

// ===== hdl/protobuf_field_scanner_core.sv =====
// Protobuf field scanner core: one byte per cycle while ready, one result per message.
// Throughput: one byte per cycle while skid is free; the scan state updates in one pass.
// On the last accepted byte, the result registers into head, or skid if head stalls.
// A two-entry result buffer (head and skid) lets bytes flow while a result waits.
// Reset (rst_n low, async): scan goes to key phase, count clears, buffer empties,
// counted_field returns to 1.
module protobuf_field_scanner_core #(
    parameter int COUNT_WIDTH  = 32,
    parameter int LENGTH_WIDTH = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    pfs_byte_if.sink                        bytes,
    pfs_result_if.source                    results,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pfs_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

`include "protobuf_field_scanner_core_assert.svh"

    logic                             accept;
    logic [pfs_pkg::FIELD_WIDTH-1:0]  counted_field;
    logic                             res_valid;
    pfs_pkg::result_t                 res;

    logic              head_valid_reg, head_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    pfs_pkg::result_t  head_reg, head_next;
    pfs_pkg::result_t  skid_reg, skid_next;
    logic              push;
    logic              pop;

    // Configuration register block.
    pfs_apb_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .counted_field (counted_field)
    );

    // Take a byte whenever the skid entry is free; the head may still be waiting.
    assign bytes.ready = !skid_valid_reg;
    assign accept      = bytes.valid && bytes.ready;

    pfs_scanner #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_scanner
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (bytes.data_byte),
        .last          (bytes.last),
        .counted_field (counted_field),
        .result_valid  (res_valid),
        .result        (res)
    );

    assign push = res_valid;
    assign pop  = head_valid_reg && results.ready;

    // Result buffer: head drives the port, skid catches a result while head stalls.
    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // no push possible here: ready is low while skid holds a result
            if (pop)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg || pop)
            begin
                head_next       = res;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign results.valid         = head_valid_reg;
    assign results.payload_count = head_reg.payload_count;
    assign results.status        = head_reg.status;

    `PFS_ASSERT_NOW(a_skid_behind_head, skid_valid_reg, head_valid_reg)
    `PFS_ASSERT_NEXT(a_stalled_push_to_skid, push && head_valid_reg && !pop, skid_valid_reg)
    `PFS_ASSERT_NEXT(a_drain_empties, pop && !skid_valid_reg && !push, !head_valid_reg)
    `PFS_ASSERT_NOW(a_status_code, head_valid_reg, head_reg.status != 2'd3)

endmodule
